[design/motor_feedback_angle_tracker_assert.svh]
// Assertion macros used by the tracker top module.
// Both expect a signal named clock, and MFAT_CHECK also reset, in the module that uses them.
`ifndef MOTOR_FEEDBACK_ANGLE_TRACKER_ASSERT_SVH
`define MOTOR_FEEDBACK_ANGLE_TRACKER_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define MFAT_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check a property at every clock edge, reset included.
`define MFAT_CHECK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

[design/mfat_pkg.sv]
package mfat_pkg;

   // Field widths
   localparam int ID_W      = 11;
   localparam int WORD_W    = 16;
   localparam int SLOT_W    = 3;
   localparam int CSR_IDX_W = 3;
   localparam int NUM_SLOTS = 7;

   // Tracking arithmetic
   localparam int ENCODER_SPAN = 8191;
   localparam int GLITCH_LIMIT = 1250;
   localparam int ACC_W        = 48;
   localparam int GAIN_W       = 16;
   localparam int DELTA_W      = WORD_W + 2;
   localparam int INC_W        = DELTA_W + GAIN_W + 1;

   localparam logic signed [DELTA_W-1:0] SPAN_D      = DELTA_W'(ENCODER_SPAN);
   localparam logic signed [DELTA_W-1:0] LIMIT_D     = DELTA_W'(GLITCH_LIMIT);
   localparam logic signed [DELTA_W-1:0] NEG_LIMIT_D = -DELTA_W'(GLITCH_LIMIT);

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   // Slot codes
   localparam logic [SLOT_W-1:0] SLOT_ARM  = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_TURN = 3'd5;

   // Track codes for the two multi-turn slots
   localparam logic TRACK_ARM  = 1'b0;
   localparam logic TRACK_TURN = 1'b1;

   // Motor ID defaults after reset, by slot
   localparam logic [ID_W-1:0] ID_RESET [NUM_SLOTS] =
      '{11'd517, 11'd513, 11'd514, 11'd515, 11'd516, 11'd518, 11'd521};

   // Gear gains, unsigned Q0.24 degrees per encoder count, by track
   localparam logic [GAIN_W-1:0] TRACK_GAIN [2] = '{16'd38809, 16'd4655};

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
   } mfat_match_type;

   typedef struct packed {
      logic                     matched;
      logic [SLOT_W-1:0]        slot;
      logic [WORD_W-1:0]        angle;
      logic signed [WORD_W-1:0] speed;
      logic signed [WORD_W-1:0] current;
   } mfat_stage_type;

   typedef struct packed {
      logic              valid;
      logic              sel;
      logic [WORD_W-1:0] angle;
      logic              reverse;
   } mfat_trk_req_type;

   typedef struct packed {
      logic                     matched;
      logic [SLOT_W-1:0]        slot;
      logic [WORD_W-1:0]        angle_out;
      logic signed [WORD_W-1:0] speed_out;
      logic signed [WORD_W-1:0] current_out;
      logic signed [ACC_W-1:0]  total_angle;
   } mfat_result_type;

endpackage

[design/mfat_if.sv]
// Feedback frame channel
interface mfat_req_if import mfat_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [ID_W-1:0]          frame_id;
   logic [WORD_W-1:0]        angle_word;
   logic signed [WORD_W-1:0] speed_word;
   logic signed [WORD_W-1:0] current_word;

   modport source (output valid, frame_id, angle_word, speed_word, current_word,
                   input ready);
   modport sink   (input valid, frame_id, angle_word, speed_word, current_word,
                   output ready);
endinterface

// Result channel
interface mfat_rsp_if import mfat_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     matched;
   logic [SLOT_W-1:0]        slot;
   logic [WORD_W-1:0]        angle_out;
   logic signed [WORD_W-1:0] speed_out;
   logic signed [WORD_W-1:0] current_out;
   logic signed [ACC_W-1:0]  total_angle;

   modport source (output valid, matched, slot, angle_out, speed_out, current_out,
                   total_angle, input ready);
   modport sink   (input valid, matched, slot, angle_out, speed_out, current_out,
                   total_angle, output ready);
endinterface

// Register write channel
interface mfat_csr_if import mfat_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [ID_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[design/mfat_id_match.sv]
module mfat_id_match import mfat_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   mfat_csr_if.sink       csr,
   input  logic [ID_W-1:0] frame_id,
   output mfat_match_type match
);

   logic [ID_W-1:0] id_ff [NUM_SLOTS];
   logic [ID_W-1:0] id_in [NUM_SLOTS];

   // Writes are always taken; indexes past the last slot are dropped
   assign csr.ready = 1'b1;

   always_comb begin
      id_in = id_ff;
      if (csr.valid && (csr.index < CSR_IDX_W'(NUM_SLOTS))) begin
         id_in[csr.index] = csr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff <= ID_RESET;
      end else begin
         id_ff <= id_in;
      end
   end

   // Compare against all IDs; the lowest matching slot wins
   always_comb begin
      match.hit  = 1'b0;
      match.slot = '0;
      for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
         if (id_ff[s] == frame_id) begin
            match.hit  = 1'b1;
            match.slot = SLOT_W'(s);
         end
      end
   end

endmodule

[design/mfat_track.sv]
module mfat_track import mfat_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  mfat_trk_req_type        trk,
   output logic signed [ACC_W-1:0] total
);

   logic [WORD_W-1:0]       prev_ff [2];
   logic [WORD_W-1:0]       prev_in [2];
   logic                    seeded_ff [2];
   logic                    seeded_in [2];
   logic signed [ACC_W-1:0] accum_ff [2];
   logic signed [ACC_W-1:0] accum_in [2];
   logic signed [INC_W-1:0] inc_ff;
   logic signed [INC_W-1:0] inc_in;
   logic                    sel_ff;
   logic                    sel_in;
   logic                    upd_ff;
   logic                    upd_in;

   logic signed [DELTA_W-1:0] cur_s;
   logic signed [DELTA_W-1:0] prev_s;
   logic signed [DELTA_W-1:0] diff_s;
   logic signed [DELTA_W-1:0] wrap_fwd;
   logic signed [DELTA_W-1:0] wrap_rev;
   logic signed [DELTA_W-1:0] delta_s;
   logic signed [GAIN_W:0]    gain_s;
   logic signed [ACC_W:0]     sum_s;

   // Wrapped encoder delta in the direction of the speed sign
   always_comb begin
      cur_s    = $signed({2'b00, trk.angle});
      prev_s   = $signed({2'b00, prev_ff[trk.sel]});
      diff_s   = cur_s - prev_s;
      wrap_fwd = diff_s + SPAN_D;
      wrap_rev = diff_s - SPAN_D;
      delta_s  = '0;
      if (!trk.reverse) begin
         if (cur_s < prev_s) begin
            if ((wrap_fwd > 0) && (wrap_fwd < LIMIT_D)) begin
               delta_s = wrap_fwd;
            end
         end else if (diff_s > 0) begin
            delta_s = diff_s;
         end
      end else begin
         if (cur_s > prev_s) begin
            if ((wrap_rev < 0) && (wrap_rev > NEG_LIMIT_D)) begin
               delta_s = wrap_rev;
            end
         end else if (diff_s < 0) begin
            delta_s = diff_s;
         end
      end
      // The first frame of a track only seeds the last angle
      if (!seeded_ff[trk.sel]) begin
         delta_s = '0;
      end
   end

   // Scale by the gear gain and latch the increment
   always_comb begin
      gain_s    = $signed({1'b0, TRACK_GAIN[trk.sel]});
      prev_in   = prev_ff;
      seeded_in = seeded_ff;
      inc_in    = inc_ff;
      sel_in    = sel_ff;
      upd_in    = advance ? trk.valid : upd_ff;
      if (trk.valid) begin
         prev_in[trk.sel]   = trk.angle;
         seeded_in[trk.sel] = 1'b1;
         inc_in             = INC_W'(delta_s) * INC_W'(gain_s);
         sel_in             = trk.sel;
      end
   end

   // Add the increment and clamp at the accumulator limits
   always_comb begin
      sum_s = (ACC_W+1)'(accum_ff[sel_ff]) + (ACC_W+1)'(inc_ff);
      if (sum_s[ACC_W] != sum_s[ACC_W-1]) begin
         total = sum_s[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         total = sum_s[ACC_W-1:0];
      end
      accum_in = accum_ff;
      if (advance && upd_ff) begin
         accum_in[sel_ff] = total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '{default: '0};
         seeded_ff <= '{default: 1'b0};
         accum_ff  <= '{default: '0};
         upd_ff    <= 1'b0;
      end else begin
         prev_ff   <= prev_in;
         seeded_ff <= seeded_in;
         accum_ff  <= accum_in;
         upd_ff    <= upd_in;
      end
   end

   always_ff @(posedge clock) begin
      inc_ff <= inc_in;
      sel_ff <= sel_in;
   end

endmodule

[design/motor_feedback_angle_tracker.sv]
// Motor feedback angle tracker.
// req carries one feedback frame per item: frame_id, angle_word, speed_word
// and current_word. The frame ID is matched against seven motor IDs held in
// registers written through csr (index 0 to 6; a higher index is dropped,
// csr.ready is always high). rsp returns one item per request: the matching
// slot and its words, and for the arm and turntable slots the multi-turn
// angle in signed Q24.24 degrees. A frame that matches no ID returns an
// all-zero item with matched low and changes no state.
// Between acceptance and rsp.valid lie an input stage with the ID compare, a
// stage with the wrapped delta and the gain multiply, and the accumulate stage
// that loads the output register. One item is taken per cycle while rsp is
// not stalled; the 48-bit add and clamp of the accumulator closes on itself
// each cycle, so back-to-back frames of one motor are tracked at full rate.
// When rsp.ready is low with a result waiting, the whole pipeline holds and
// req.ready drops in the same cycle; the result stays on rsp unchanged.
// Reset restores the default motor IDs, clears the pipeline and clears the
// angle trackers to zero, not yet seeded.
`include "motor_feedback_angle_tracker_assert.svh"

module motor_feedback_angle_tracker import mfat_pkg::*; (
   input logic      clock,
   input logic      reset,
   mfat_req_if.sink req,
   mfat_rsp_if.source rsp,
   mfat_csr_if.sink csr
);

   logic            advance;
   mfat_match_type  match;
   mfat_trk_req_type trk;
   logic signed [ACC_W-1:0] total;
   logic            tracked0;
   logic            tracked1;

   logic            s0_valid_ff, s0_valid_in;
   mfat_stage_type  s0_ff, s0_in;
   logic            s1_valid_ff, s1_valid_in;
   mfat_stage_type  s1_ff, s1_in;
   logic            rsp_valid_ff, rsp_valid_in;
   mfat_result_type rsp_ff, rsp_in;

   // Move the pipeline whenever the output register is free or being taken
   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = advance;

   mfat_id_match u_id_match (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr),
      .frame_id (req.frame_id),
      .match    (match)
   );

   assign tracked0 = s0_ff.matched && ((s0_ff.slot == SLOT_ARM) || (s0_ff.slot == SLOT_TURN));
   assign tracked1 = s1_ff.matched && ((s1_ff.slot == SLOT_ARM) || (s1_ff.slot == SLOT_TURN));

   always_comb begin
      trk.valid   = advance && s0_valid_ff && tracked0;
      trk.sel     = (s0_ff.slot == SLOT_TURN) ? TRACK_TURN : TRACK_ARM;
      trk.angle   = s0_ff.angle;
      trk.reverse = s0_ff.speed[WORD_W-1];
   end

   mfat_track u_track (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .trk     (trk),
      .total   (total)
   );

   // Advance the stages; hold everything while the output is stalled
   always_comb begin
      s0_valid_in  = s0_valid_ff;
      s0_in        = s0_ff;
      s1_valid_in  = s1_valid_ff;
      s1_in        = s1_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         s0_valid_in   = req.valid;
         s0_in.matched = match.hit;
         s0_in.slot    = match.slot;
         s0_in.angle   = req.angle_word;
         s0_in.speed   = req.speed_word;
         s0_in.current = req.current_word;
         s1_valid_in   = s0_valid_ff;
         s1_in         = s0_ff;
         rsp_valid_in  = s1_valid_ff;
         // Zero every field of an unmatched item
         rsp_in = '0;
         if (s1_ff.matched) begin
            rsp_in.matched     = 1'b1;
            rsp_in.slot        = s1_ff.slot;
            rsp_in.angle_out   = s1_ff.angle;
            rsp_in.speed_out   = s1_ff.speed;
            rsp_in.current_out = s1_ff.current;
            rsp_in.total_angle = tracked1 ? total : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_ff  <= s0_in;
      s1_ff  <= s1_in;
      rsp_ff <= rsp_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.matched     = rsp_ff.matched;
   assign rsp.slot        = rsp_ff.slot;
   assign rsp.angle_out   = rsp_ff.angle_out;
   assign rsp.speed_out   = rsp_ff.speed_out;
   assign rsp.current_out = rsp_ff.current_out;
   assign rsp.total_angle = rsp_ff.total_angle;

   `MFAT_CHECK_ALWAYS(a_reset_empties, $past(reset) |-> !rsp.valid, "result after reset")
   `MFAT_CHECK(a_nomatch_zero,
      rsp.valid && !rsp.matched |->
         rsp.slot == '0 && rsp.total_angle == '0 && rsp.angle_out == '0,
      "unmatched item not zero")
   `MFAT_CHECK(a_total_tracked,
      rsp.valid && rsp.total_angle != '0 |-> rsp.slot == SLOT_ARM || rsp.slot == SLOT_TURN,
      "angle on untracked slot")
   `MFAT_CHECK(a_slot_range,
      rsp.valid && rsp.matched |-> rsp.slot != SLOT_W'(NUM_SLOTS),
      "slot out of range")

endmodule

[test/tb_motor_feedback_angle_tracker.sv]
`timescale 1ns / 1ps

module tb_motor_feedback_angle_tracker;
   import mfat_pkg::*;

   localparam int CLOCK_HALF   = 5;
   localparam int PIPE_LATENCY = 3;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int HOLD_CYCLES  = 64;
   localparam int REPORT_LIMIT = 10;
   localparam int PHASE_ITEMS  = 205;
   localparam int NUM_PHASES   = 5;
   localparam int DIR_ROWS     = 25;

   // Tracking arithmetic, kept apart from the design's own constants
   localparam int     WRAP_SPAN      = 8191;
   localparam int     GLITCH_COUNTS  = 1250;
   localparam int     ENCODER_COUNTS = 8192;
   localparam longint ARM_GAIN       = 38809;
   localparam longint TURN_GAIN      = 4655;
   localparam longint ACC_HI         = (longint'(1) <<< 47) - 1;
   localparam longint ACC_LO         = -ACC_HI - 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ARM_ID, REG_CHASSIS_ONE_ID, REG_CHASSIS_TWO_ID, REG_CHASSIS_THREE_ID,
      REG_CHASSIS_FOUR_ID, REG_TURNTABLE_ID, REG_GIMBAL_ID, REG_SPARE
   } csr_index_type;

   localparam logic [SLOT_W-1:0] SLOT_CH1    = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_CH2    = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_CH3    = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_CH4    = 3'd4;
   localparam logic [SLOT_W-1:0] SLOT_GIMBAL = 3'd6;

   localparam logic [ID_W-1:0] DEFAULT_IDS [NUM_SLOTS] =
      '{11'd517, 11'd513, 11'd514, 11'd515, 11'd516, 11'd518, 11'd521};

   typedef struct packed {
      logic [ID_W-1:0]   fid;
      logic [WORD_W-1:0] ang;
      logic [WORD_W-1:0] spd;
      logic [WORD_W-1:0] cur;
      bit                typed;
      bit                exp_matched;
      logic [SLOT_W-1:0] exp_slot;
   } frame_row_type;

   // Directed frames under the default IDs; typed rows carry their result
   frame_row_type frame_table [DIR_ROWS] = '{
      // unmatched IDs at both extremes
      '{11'd0,    16'hFFFF, 16'h7FFF,    16'h8000, 1'b1, 1'b0, SLOT_ARM},
      '{11'd2047, 16'h0000, 16'h8000,    16'h7FFF, 1'b1, 1'b0, SLOT_ARM},
      // untracked slots echo their words
      '{11'd513,  16'hFFFF, 16'h8000,    16'h7FFF, 1'b1, 1'b1, SLOT_CH1},
      '{11'd514,  16'h0000, 16'h7FFF,    16'h8000, 1'b1, 1'b1, SLOT_CH2},
      '{11'd515,  16'h5555, 16'hAAAA,    16'h5555, 1'b1, 1'b1, SLOT_CH3},
      '{11'd516,  16'hAAAA, 16'h5555,    16'hAAAA, 1'b1, 1'b1, SLOT_CH4},
      '{11'd521,  16'd8191, 16'h0000,    16'h0000, 1'b1, 1'b1, SLOT_GIMBAL},
      // arm: first frame seeds only
      '{11'd517,  16'd100,  16'h0000,    16'h0001, 1'b1, 1'b1, SLOT_ARM},
      '{11'd517,  16'd600,  16'd10,      16'h0002, 1'b0, 1'b0, SLOT_ARM},
      '{11'd517,  16'd8000, 16'd10,      16'h0003, 1'b0, 1'b0, SLOT_ARM},
      // forward wrap just under and at the glitch limit
      '{11'd517,  16'd1058, 16'd10,      16'h0004, 1'b0, 1'b0, SLOT_ARM},
      '{11'd517,  16'd8000, 16'd10,      16'h0005, 1'b0, 1'b0, SLOT_ARM},
      '{11'd517,  16'd1059, 16'd10,      16'h0006, 1'b0, 1'b0, SLOT_ARM},
      '{11'd517,  16'd1059, 16'h0000,    16'h0007, 1'b0, 1'b0, SLOT_ARM},
      // reverse wrap just under and at the limit, the latter above span
      '{11'd517,  16'd8001, -16'sd1,     16'h0008, 1'b0, 1'b0, SLOT_ARM},
      '{11'd517,  16'd14942, -16'sd1,    16'h0009, 1'b0, 1'b0, SLOT_ARM},
      '{11'd517,  16'd14000, -16'sd300,  16'h000A, 1'b0, 1'b0, SLOT_ARM},
      // delta sign against the speed in both directions
      '{11'd517,  16'd5000, 16'd5,       16'h000B, 1'b0, 1'b0, SLOT_ARM},
      '{11'd517,  16'd14000, -16'sd5,    16'h000C, 1'b0, 1'b0, SLOT_ARM},
      // full-scale jumps
      '{11'd517,  16'hFFFF, 16'h7FFF,    16'h000D, 1'b0, 1'b0, SLOT_ARM},
      '{11'd517,  16'h0000, 16'h8000,    16'h000E, 1'b0, 1'b0, SLOT_ARM},
      // turntable: seed, wrap, glitches both ways
      '{11'd518,  16'd8191, 16'h0000,    16'h7FFF, 1'b1, 1'b1, SLOT_TURN},
      '{11'd518,  16'd1057, 16'd1,       16'h8000, 1'b0, 1'b0, SLOT_TURN},
      '{11'd518,  16'd0,    16'd100,     16'h1234, 1'b0, 1'b0, SLOT_TURN},
      '{11'd518,  16'hFFFF, -16'sd1,     16'hEDCB, 1'b0, 1'b0, SLOT_TURN}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   mfat_req_if req_if ();
   mfat_rsp_if rsp_if ();
   mfat_csr_if csr_if ();

   motor_feedback_angle_tracker DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   // Predicted state of the block
   logic [ID_W-1:0]   motor_ids    [NUM_SLOTS];
   logic [WORD_W-1:0] held_angle   [NUM_SLOTS];
   logic [WORD_W-1:0] held_speed   [NUM_SLOTS];
   logic [WORD_W-1:0] held_current [NUM_SLOTS];
   logic [WORD_W-1:0] trk_prev     [2];
   bit                trk_seeded   [2];
   longint            trk_accum    [2];

   mfat_result_type awaited_results [$];
   logic [WORD_W-1:0] gen_angle [2];
   int fail_count = 0;
   int result_count = 0;
   bit send_idle = 1'b1;
   bit recv_idle = 1'b1;
   bit hold_rsp = 1'b0;

   always #CLOCK_HALF clock = ~clock;

   // Advance the multi-turn angle of one tracked motor
   function automatic void advance_turns(input logic trk, input logic [WORD_W-1:0] ang,
                                         input logic signed [WORD_W-1:0] spd);
      int     cur_a;
      int     prev_a;
      int     delta;
      longint gain;
      longint step;
      longint acc;
      if (!trk_seeded[trk]) begin
         trk_prev[trk] = ang;
         trk_seeded[trk] = 1'b1;
         return;
      end
      cur_a = int'(ang);
      prev_a = int'(trk_prev[trk]);
      if (spd >= 0) begin
         if (cur_a < prev_a) begin
            delta = WRAP_SPAN + cur_a - prev_a;
            if (delta >= GLITCH_COUNTS || delta <= -GLITCH_COUNTS) delta = 0;
         end else begin
            delta = cur_a - prev_a;
         end
         if (delta < 0) delta = 0;
      end else begin
         if (cur_a > prev_a) begin
            delta = cur_a - prev_a - WRAP_SPAN;
            if (delta >= GLITCH_COUNTS || delta <= -GLITCH_COUNTS) delta = 0;
         end else begin
            delta = cur_a - prev_a;
         end
         if (delta > 0) delta = 0;
      end
      trk_prev[trk] = ang;
      if (delta == 0) return;
      gain = (trk == TRACK_TURN) ? TURN_GAIN : ARM_GAIN;
      step = longint'(delta) * gain;
      acc = trk_accum[trk];
      // clamp at the signed 48-bit limits
      if (step > 0) acc = (acc > ACC_HI - step) ? ACC_HI : acc + step;
      else acc = (acc < ACC_LO - step) ? ACC_LO : acc + step;
      trk_accum[trk] = acc;
   endfunction

   // Work out the result of one frame and update the predicted state
   function automatic mfat_result_type predict_frame(input logic [ID_W-1:0] fid,
                                                     input logic [WORD_W-1:0] ang,
                                                     input logic [WORD_W-1:0] spd,
                                                     input logic [WORD_W-1:0] cur);
      mfat_result_type r;
      int              hit;
      logic            trk_sel;
      r = '0;
      hit = -1;
      // lowest matching slot wins
      for (int s = 0; s < NUM_SLOTS; s++) begin
         if (hit < 0 && motor_ids[s] == fid) hit = s;
      end
      if (hit < 0) return r;
      held_angle[hit] = ang;
      held_speed[hit] = spd;
      held_current[hit] = cur;
      r.matched = 1'b1;
      r.slot = SLOT_W'(hit);
      r.angle_out = held_angle[hit];
      r.speed_out = held_speed[hit];
      r.current_out = held_current[hit];
      if (r.slot == SLOT_ARM || r.slot == SLOT_TURN) begin
         trk_sel = (r.slot == SLOT_TURN) ? TRACK_TURN : TRACK_ARM;
         advance_turns(trk_sel, ang, spd);
         r.total_angle = ACC_W'(trk_accum[trk_sel]);
      end
      return r;
   endfunction

   // Offer one frame, and on acceptance queue its expected result
   task automatic send_frame(input logic [ID_W-1:0] fid, input logic [WORD_W-1:0] ang,
                             input logic [WORD_W-1:0] spd, input logic [WORD_W-1:0] cur,
                             input bit typed, input mfat_result_type typed_res);
      int              gap;
      mfat_result_type predicted;
      gap = send_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_if.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid = 1'b1;
      req_if.frame_id = fid;
      req_if.angle_word = ang;
      req_if.speed_word = spd;
      req_if.current_word = cur;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predicted = predict_frame(fid, ang, spd, cur);
      awaited_results.push_back(typed ? typed_res : predicted);
   endtask

   // Write one ID register; the spare index is dropped by the block
   task automatic csr_write(input csr_index_type idx, input logic [ID_W-1:0] value);
      @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.index = idx;
      csr_if.data = value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      if (idx != REG_SPARE) motor_ids[idx] = value;
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic load_ids(input logic [ID_W-1:0] ids [NUM_SLOTS]);
      for (int i = 0; i < NUM_SLOTS; i++) csr_write(csr_index_type'(i), ids[i]);
      csr_write(REG_SPARE, ID_W'($urandom));
   endtask

   // Stop offering, wait for every result, then let the pipeline empty
   task automatic settle();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   // Draw one frame: mostly tracked motors with plausible motion
   task automatic gen_frame(output logic [ID_W-1:0] fid, output logic [WORD_W-1:0] ang,
                            output logic [WORD_W-1:0] spd, output logic [WORD_W-1:0] cur);
      int                pick;
      int                style;
      int                step;
      int                slot_pick;
      bit                fwd;
      logic              trk_sel;
      logic [WORD_W-1:0] base;
      pick = $urandom_range(0, 99);
      cur = WORD_W'($urandom);
      ang = WORD_W'($urandom);
      spd = WORD_W'($urandom);
      if (pick < 20) begin
         fid = ID_W'($urandom);
         return;
      end
      if (pick < 35) begin
         slot_pick = $urandom_range(0, 4);
         slot_pick = (slot_pick == 4) ? int'(SLOT_GIMBAL) : slot_pick + 1;
         fid = motor_ids[slot_pick];
         return;
      end
      trk_sel = (pick < 70) ? TRACK_ARM : TRACK_TURN;
      fid = motor_ids[(trk_sel == TRACK_TURN) ? SLOT_TURN : SLOT_ARM];
      style = $urandom_range(0, 9);
      if (style < 8) begin
         step = (style == 6) ? $urandom_range(1240, 1260) : $urandom_range(0, 1300);
         fwd = 1'($urandom_range(0, 1));
         base = WORD_W'(gen_angle[trk_sel] % ENCODER_COUNTS);
         ang = fwd ? WORD_W'((base + step) % ENCODER_COUNTS)
                   : WORD_W'((base + ENCODER_COUNTS - step) % ENCODER_COUNTS);
         // speed follows the motion, except for the disagreeing style
         if (fwd != (style == 7))
            spd = ($urandom_range(0, 15) == 0) ? '0 : WORD_W'($urandom_range(0, 32767));
         else
            spd = WORD_W'(-$urandom_range(1, 32768));
      end
      gen_angle[trk_sel] = ang;
   endtask

   // Compare one accepted result with the oldest expectation
   function automatic void check_result(input mfat_result_type got);
      mfat_result_type want;
      result_count++;
      if (awaited_results.size() == 0) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT)
            $display("result %0d arrived with nothing expected: slot=%0d total=%h",
                     result_count, got.slot, got.total_angle);
         return;
      end
      want = awaited_results.pop_front();
      if (got.matched !== want.matched || got.slot !== want.slot ||
          got.angle_out !== want.angle_out || got.speed_out !== want.speed_out ||
          got.current_out !== want.current_out || got.total_angle !== want.total_angle) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT) begin
            $display("result %0d expected: m=%b slot=%0d ang=%h spd=%h cur=%h total=%h",
                     result_count, want.matched, want.slot, want.angle_out,
                     want.speed_out, want.current_out, want.total_angle);
            $display("result %0d actual:   m=%b slot=%0d ang=%h spd=%h cur=%h total=%h",
                     result_count, got.matched, got.slot, got.angle_out,
                     got.speed_out, got.current_out, got.total_angle);
         end
      end
   endfunction

   // Result side: random stalls, one long hold-off on request
   initial begin : result_sink
      int              stall;
      mfat_result_type got;
      rsp_if.ready = 1'b0;
      forever begin
         stall = recv_idle ? $urandom_range(0, 7) : 0;
         if (hold_rsp) begin
            stall = HOLD_CYCLES;
            hold_rsp = 1'b0;
         end
         if (stall > 0) begin
            @(negedge clock);
            rsp_if.ready = 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_if.ready = 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         got.matched = rsp_if.matched;
         got.slot = rsp_if.slot;
         got.angle_out = rsp_if.angle_out;
         got.speed_out = rsp_if.speed_out;
         got.current_out = rsp_if.current_out;
         got.total_angle = rsp_if.total_angle;
         check_result(got);
      end
   end

   // Stop a hung run
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      logic [ID_W-1:0]   new_ids [NUM_SLOTS];
      logic [ID_W-1:0]   fid;
      logic [WORD_W-1:0] ang;
      logic [WORD_W-1:0] spd;
      logic [WORD_W-1:0] cur;
      mfat_result_type   typed_res;
      req_if.valid = 1'b0;
      req_if.frame_id = '0;
      req_if.angle_word = '0;
      req_if.speed_word = '0;
      req_if.current_word = '0;
      csr_if.valid = 1'b0;
      csr_if.index = REG_ARM_ID;
      csr_if.data = '0;
      motor_ids = DEFAULT_IDS;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         held_angle[s] = '0;
         held_speed[s] = '0;
         held_current[s] = '0;
      end
      for (int t = 0; t < 2; t++) begin
         trk_prev[t] = '0;
         trk_seeded[t] = 1'b0;
         trk_accum[t] = 0;
         gen_angle[t] = '0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Walk the directed table
      foreach (frame_table[i]) begin
         typed_res = '0;
         if (frame_table[i].exp_matched) begin
            typed_res.matched = 1'b1;
            typed_res.slot = frame_table[i].exp_slot;
            typed_res.angle_out = frame_table[i].ang;
            typed_res.speed_out = frame_table[i].spd;
            typed_res.current_out = frame_table[i].cur;
         end
         send_frame(frame_table[i].fid, frame_table[i].ang, frame_table[i].spd,
                    frame_table[i].cur, frame_table[i].typed, typed_res);
      end
      settle();

      // Random phases, each under its own ID map
      for (int ph = 1; ph <= NUM_PHASES; ph++) begin
         for (int s = 0; s < NUM_SLOTS; s++) new_ids[s] = ID_W'($urandom_range(1, 2046));
         case (ph)
            1: begin
               new_ids[REG_ARM_ID] = '0;
               new_ids[REG_TURNTABLE_ID] = '1;
            end
            2: begin
               // every slot shares one ID, so only the arm can match
               for (int s = 0; s < NUM_SLOTS; s++) new_ids[s] = '1;
            end
            3: begin
               new_ids[REG_CHASSIS_TWO_ID] = new_ids[REG_CHASSIS_ONE_ID];
               new_ids[REG_GIMBAL_ID] = new_ids[REG_ARM_ID];
            end
            4: begin
               new_ids[REG_ARM_ID] = '1;
               new_ids[REG_TURNTABLE_ID] = '0;
               new_ids[REG_GIMBAL_ID] = '0;
            end
            default: new_ids = DEFAULT_IDS;
         endcase
         load_ids(new_ids);
         send_idle = (ph != 3 && ph != 4);
         recv_idle = (ph != 4);
         hold_rsp = (ph == 3);
         repeat (PHASE_ITEMS) begin
            gen_frame(fid, ang, spd, cur);
            send_frame(fid, ang, spd, cur, 1'b0, '0);
         end
         settle();
      end

      if (fail_count == 0 && awaited_results.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/mfat_pkg.sv
design/mfat_if.sv
design/mfat_id_match.sv
design/mfat_track.sv
design/motor_feedback_angle_tracker.sv
test/tb_motor_feedback_angle_tracker.sv
